// File: hdl/qrrsm_pkg.sv
package qrrsm_pkg;

    localparam int unsigned RULE_ROWS_DEF    = 32;
    localparam int unsigned MEASURE_BITS_DEF = 24;

    // Widths of the item fields
    localparam int unsigned OP_W     = 3;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned ALERT_W  = 2;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned ACTION_W = 8;
    localparam int unsigned SEL_W    = 3;
    localparam int unsigned FIELD_W  = 24;

    // Opcodes
    localparam logic [OP_W-1:0] OP_KEYS    = 3'd0;
    localparam logic [OP_W-1:0] OP_BOUND   = 3'd1;
    localparam logic [OP_W-1:0] OP_ALERT   = 3'd2;
    localparam logic [OP_W-1:0] OP_RECOVER = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Bound slots of a row
    localparam int unsigned BND_SLOTS    = 6;
    localparam int unsigned BND_LAT_MIN  = 0;
    localparam int unsigned BND_LAT_MAX  = 1;
    localparam int unsigned BND_JIT_MIN  = 2;
    localparam int unsigned BND_JIT_MAX  = 3;
    localparam int unsigned BND_LOSS_MIN = 4;
    localparam int unsigned BND_LOSS_MAX = 5;

    typedef struct packed {
        logic                valid;
        logic [STATE_W-1:0]  state_key;
        logic [ALERT_W-1:0]  alert_key;
        logic [ACTION_W-1:0] action;
        logic [STATE_W-1:0]  next_state;
    } t_key_word;

    typedef struct packed {
        logic load;
        logic clr_run;
        logic srch_run;
        logic test_init;
        logic test_run;
        logic trans_rd;
        logic trans_apply;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic srch_done;
        logic test_done;
        logic flags_any;
    } t_dp_sts;

endpackage

// File: hdl/qrrsm_ram.sv
module qrrsm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/qrrsm_ctrl.sv
module qrrsm_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [qrrsm_pkg::OP_W-1:0]   i_opcode,
    output logic                         o_valid,
    input  logic                         i_ready,
    output qrrsm_pkg::t_dp_cmd           o_cmd,
    input  qrrsm_pkg::t_dp_sts           i_sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_TEST,
        ST_TRANS,
        ST_APPLY,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_rcv, n_rcv;
    logic   r_clr_item, n_clr_item;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_rcv       = r_rcv;
        n_clr_item  = r_clr_item;
        o_cmd       = '0;
        o_cmd.load  = accept;

        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        qrrsm_pkg::OP_ALERT: begin
                            n_rcv   = 1'b0;
                            n_state = ST_SEARCH;
                        end
                        qrrsm_pkg::OP_RECOVER: begin
                            n_rcv   = 1'b1;
                            n_state = ST_SEARCH;
                        end
                        qrrsm_pkg::OP_CLEAR: begin
                            n_clr_item = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (!i_sts.srch_done) begin
                    o_cmd.srch_run = 1'b1;
                end else if (r_rcv) begin
                    n_state = ST_TRANS;
                end else begin
                    o_cmd.test_init = 1'b1;
                    n_state         = ST_TEST;
                end
            end
            ST_TEST: begin
                if (!i_sts.test_done) begin
                    o_cmd.test_run = 1'b1;
                end else begin
                    n_state = i_sts.flags_any ? ST_TRANS : ST_DONE;
                end
            end
            ST_TRANS: begin
                o_cmd.trans_rd = 1'b1;
                n_state        = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.trans_apply = 1'b1;
                n_state           = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
            r_rcv       <= 1'b0;
            r_clr_item  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rcv       <= n_rcv;
            r_clr_item  <= (n_state == ST_IDLE) ? 1'b0 : n_clr_item;
        end
    end

endmodule

// File: hdl/qrrsm_dpath.sv
module qrrsm_dpath #(
    parameter int unsigned RULE_ROWS    = qrrsm_pkg::RULE_ROWS_DEF,
    parameter int unsigned MEASURE_BITS = qrrsm_pkg::MEASURE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qrrsm_pkg::t_dp_cmd               i_cmd,
    output qrrsm_pkg::t_dp_sts               o_sts,
    input  logic [qrrsm_pkg::OP_W-1:0]       i_opcode,
    input  logic [qrrsm_pkg::IDX_W-1:0]      i_rule_index,
    input  logic [qrrsm_pkg::ALERT_W-1:0]    i_alert_type,
    input  logic [qrrsm_pkg::STATE_W-1:0]    i_rule_state,
    input  logic [qrrsm_pkg::ACTION_W-1:0]   i_rule_action,
    input  logic [qrrsm_pkg::STATE_W-1:0]    i_rule_next_state,
    input  logic [qrrsm_pkg::SEL_W-1:0]      i_bound_select,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_bound_value,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_latency,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_jitter,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_packet_loss,
    output logic                             o_triggered,
    output logic [qrrsm_pkg::ACTION_W-1:0]   o_action_code,
    output logic [qrrsm_pkg::STATE_W-1:0]    o_state_now,
    output logic [qrrsm_pkg::IDX_W-1:0]      o_row_used
);

    localparam int unsigned RW = (RULE_ROWS > 1) ? $clog2(RULE_ROWS) : 1;
    localparam int unsigned CW = $clog2(RULE_ROWS + 1);
    localparam int unsigned MB = MEASURE_BITS;
    localparam logic [CW-1:0] ROWS_C = CW'(RULE_ROWS);
    localparam logic [RW-1:0] LAST_C = RW'(RULE_ROWS - 1);
    localparam logic [MB-1:0] NO_MAX = '1;

    // scan pointer, read pipeline and counters
    logic [CW-1:0] r_ptr;
    logic          r_live;
    logic [RW-1:0] r_drow;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_remain;
    logic          r_stop;

    // architectural state
    logic [RW-1:0]                       r_sel;
    logic [2:0]                          r_flags;
    logic [qrrsm_pkg::STATE_W-1:0]       r_pstate;
    logic                                r_trig;
    logic [qrrsm_pkg::ACTION_W-1:0]      r_act;

    // item operands
    logic [qrrsm_pkg::ALERT_W-1:0] r_alert;
    logic [MB-1:0]                 r_lat;
    logic [MB-1:0]                 r_jit;
    logic [MB-1:0]                 r_loss;

    // result register
    logic                              r_o_trig;
    logic [qrrsm_pkg::ACTION_W-1:0]    r_o_act;
    logic [qrrsm_pkg::STATE_W-1:0]     r_o_state;
    logic [qrrsm_pkg::IDX_W-1:0]       r_o_row;

    logic                   idx_ok;
    logic [RW-1:0]          waddr;
    logic [RW-1:0]          raddr;
    logic                   key_we;
    qrrsm_pkg::t_key_word   key_wdata;
    qrrsm_pkg::t_key_word   key_q;
    logic [MB-1:0]          bnd_q [qrrsm_pkg::BND_SLOTS];
    logic                   key_match;
    logic                   jit_ok, lat_ok, loss_ok;
    logic                   tst_eval, tst_fail, tst_issue, srch_issue;
    logic [2:0]             n_flags;

    assign idx_ok = 32'(i_rule_index) < 32'(RULE_ROWS);
    assign waddr  = i_cmd.clr_run ? r_ptr[RW-1:0] : RW'(i_rule_index);
    assign raddr  = i_cmd.trans_rd ? r_sel : r_ptr[RW-1:0];

    assign key_we = i_cmd.clr_run ||
                    (i_cmd.load && (i_opcode == qrrsm_pkg::OP_KEYS) && idx_ok);

    always_comb begin
        key_wdata = '0;
        if (!i_cmd.clr_run) begin
            key_wdata.valid      = 1'b1;
            key_wdata.state_key  = i_rule_state;
            key_wdata.alert_key  = i_alert_type;
            key_wdata.action     = i_rule_action;
            key_wdata.next_state = i_rule_next_state;
        end
    end

    qrrsm_ram #(
        .WIDTH ($bits(qrrsm_pkg::t_key_word)),
        .DEPTH (RULE_ROWS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_q)
    );

    for (genvar k = 0; k < qrrsm_pkg::BND_SLOTS; k++) begin : g_bnd
        localparam bit IS_MAX = (k % 2) == 1;
        logic          we;
        logic [MB-1:0] wdata;

        assign we = i_cmd.clr_run ||
                    (i_cmd.load && (i_opcode == qrrsm_pkg::OP_BOUND) && idx_ok &&
                     (i_bound_select == qrrsm_pkg::SEL_W'(k)));
        assign wdata = i_cmd.clr_run ? (IS_MAX ? NO_MAX : '0) : MB'(i_bound_value);

        qrrsm_ram #(
            .WIDTH (MB),
            .DEPTH (RULE_ROWS)
        ) u_bnd_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_raddr (raddr),
            .o_rdata (bnd_q[k])
        );
    end

    assign key_match = key_q.valid && (key_q.state_key == r_pstate) &&
                       (key_q.alert_key == r_alert);

    assign jit_ok  = (r_jit > bnd_q[qrrsm_pkg::BND_JIT_MIN]) &&
                     ((bnd_q[qrrsm_pkg::BND_JIT_MAX] == NO_MAX) ||
                      (r_jit < bnd_q[qrrsm_pkg::BND_JIT_MAX]));
    assign lat_ok  = (r_lat > bnd_q[qrrsm_pkg::BND_LAT_MIN]) &&
                     ((bnd_q[qrrsm_pkg::BND_LAT_MAX] == NO_MAX) ||
                      (r_lat < bnd_q[qrrsm_pkg::BND_LAT_MAX]));
    assign loss_ok = (r_loss >= bnd_q[qrrsm_pkg::BND_LOSS_MIN]) &&
                     ((bnd_q[qrrsm_pkg::BND_LOSS_MAX] == NO_MAX) ||
                      (r_loss < bnd_q[qrrsm_pkg::BND_LOSS_MAX]));

    // tests run jitter, latency, loss; the first failure sets its flag and stops
    always_comb begin
        n_flags = r_flags;
        if (!jit_ok) begin
            n_flags[0] = 1'b1;
        end else begin
            n_flags[0] = 1'b0;
            if (!lat_ok) begin
                n_flags[1] = 1'b1;
            end else begin
                n_flags[1] = 1'b0;
                n_flags[2] = !loss_ok;
            end
        end
    end

    assign tst_eval   = i_cmd.test_run && r_live && !r_stop;
    assign tst_fail   = tst_eval && !(jit_ok && lat_ok && loss_ok);
    assign tst_issue  = i_cmd.test_run && !r_stop && (r_remain != '0) && !tst_fail;
    assign srch_issue = i_cmd.srch_run && (r_ptr < ROWS_C);

    assign o_sts.clr_last  = (r_ptr[RW-1:0] == LAST_C);
    assign o_sts.srch_done = (r_ptr == ROWS_C) && !r_live;
    assign o_sts.test_done = r_stop || ((r_remain == '0) && !r_live);
    assign o_sts.flags_any = |r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_live   <= 1'b0;
            r_drow   <= '0;
            r_count  <= '0;
            r_remain <= '0;
            r_stop   <= 1'b0;
            r_sel    <= '0;
            r_flags  <= '0;
            r_pstate <= '0;
            r_trig   <= 1'b0;
            r_act    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ptr   <= '0;
                r_live  <= 1'b0;
                r_count <= '0;
                r_trig  <= 1'b0;
                r_act   <= '0;
            end else if (i_cmd.clr_run) begin
                r_ptr <= r_ptr + CW'(1);
            end else if (i_cmd.srch_run) begin
                if (srch_issue) begin
                    r_ptr  <= r_ptr + CW'(1);
                    r_drow <= r_ptr[RW-1:0];
                end
                r_live <= srch_issue;
                if (r_live && key_match) begin
                    if (r_count == '0) begin
                        r_sel <= r_drow;
                    end
                    r_count <= r_count + CW'(1);
                end
            end else if (i_cmd.test_init) begin
                r_ptr    <= CW'(r_sel);
                r_remain <= r_count;
                r_live   <= 1'b0;
                r_stop   <= 1'b0;
            end else if (i_cmd.test_run) begin
                if (tst_issue) begin
                    r_ptr    <= r_ptr + CW'(1);
                    r_remain <= r_remain - CW'(1);
                    r_drow   <= r_ptr[RW-1:0];
                end
                r_live <= tst_issue;
                if (tst_eval) begin
                    r_flags <= n_flags;
                end
                if (tst_fail) begin
                    r_sel  <= r_drow;
                    r_stop <= 1'b1;
                end
            end else if (i_cmd.trans_apply) begin
                r_pstate <= key_q.next_state;
                r_act    <= key_q.action;
                r_trig   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_alert <= i_alert_type;
            r_lat   <= MB'(i_latency);
            r_jit   <= MB'(i_jitter);
            r_loss  <= MB'(i_packet_loss);
        end
        if (i_cmd.out_load) begin
            r_o_trig  <= r_trig;
            r_o_act   <= r_act;
            r_o_state <= r_pstate;
            r_o_row   <= qrrsm_pkg::IDX_W'(r_sel);
        end
    end

    assign o_triggered   = r_o_trig;
    assign o_action_code = r_o_act;
    assign o_state_now   = r_o_state;
    assign o_row_used    = r_o_row;

endmodule

// File: hdl/qos_range_rule_state_machine_core.sv
// Rule-table state machine for QoS alerts. Each transfer carries one command (write row keys,
// write one bound, alert, recovery, clear table) and yields exactly one result. Row keys and
// bounds sit in single-port-read RAMs that are walked one row per cycle: an alert runs a
// search pass over all rows, a test pass over the matching-span rows and, if a flag is set,
// a read of the selected row; a recovery runs the search pass and the read; a clear table
// sweeps all rows. After reset the block sweeps the table to its reset contents with o_ready
// low. Commands are taken one at a time; the output register lets the next command in while
// a result waits.
module qos_range_rule_state_machine_core #(
    parameter int unsigned RULE_ROWS    = qrrsm_pkg::RULE_ROWS_DEF,
    parameter int unsigned MEASURE_BITS = qrrsm_pkg::MEASURE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [qrrsm_pkg::OP_W-1:0]       i_opcode,
    input  logic [qrrsm_pkg::IDX_W-1:0]      i_rule_index,
    input  logic [qrrsm_pkg::ALERT_W-1:0]    i_alert_type,
    input  logic [qrrsm_pkg::STATE_W-1:0]    i_rule_state,
    input  logic [qrrsm_pkg::ACTION_W-1:0]   i_rule_action,
    input  logic [qrrsm_pkg::STATE_W-1:0]    i_rule_next_state,
    input  logic [qrrsm_pkg::SEL_W-1:0]      i_bound_select,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_bound_value,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_latency,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_jitter,
    input  logic [qrrsm_pkg::FIELD_W-1:0]    i_packet_loss,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_triggered,
    output logic [qrrsm_pkg::ACTION_W-1:0]   o_action_code,
    output logic [qrrsm_pkg::STATE_W-1:0]    o_state_now,
    output logic [qrrsm_pkg::IDX_W-1:0]      o_row_used
);

    qrrsm_pkg::t_dp_cmd cmd;
    qrrsm_pkg::t_dp_sts sts;

    qrrsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    qrrsm_dpath #(
        .RULE_ROWS    (RULE_ROWS),
        .MEASURE_BITS (MEASURE_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_opcode),
        .i_rule_index      (i_rule_index),
        .i_alert_type      (i_alert_type),
        .i_rule_state      (i_rule_state),
        .i_rule_action     (i_rule_action),
        .i_rule_next_state (i_rule_next_state),
        .i_bound_select    (i_bound_select),
        .i_bound_value     (i_bound_value),
        .i_latency         (i_latency),
        .i_jitter          (i_jitter),
        .i_packet_loss     (i_packet_loss),
        .o_triggered       (o_triggered),
        .o_action_code     (o_action_code),
        .o_state_now       (o_state_now),
        .o_row_used        (o_row_used)
    );

endmodule

// File: hdl/qrrsm_chk.sv
module qrrsm_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic                             o_triggered,
    input logic [qrrsm_pkg::ACTION_W-1:0]   o_action_code,
    input logic [qrrsm_pkg::STATE_W-1:0]    o_state_now,
    input logic [qrrsm_pkg::IDX_W-1:0]      o_row_used
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_triggered) &&
            $stable(o_action_code) && $stable(o_state_now) && $stable(o_row_used))
        else $error("result changed while stalled");

    // no action without a transition
    a_idle_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_triggered |-> o_action_code == '0)
        else $error("action code set on untriggered result");

    // one command at a time: ready drops after each transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second command taken while busy");

    // reset empties the output and starts the table sweep
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output valid or ready after reset");

endmodule

bind qos_range_rule_state_machine_core qrrsm_chk u_chk (.*);

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qrrsm_pkg::*;

    localparam int unsigned ROWS         = RULE_ROWS_DEF;
    localparam int unsigned IDLE_PCT     = 34;
    localparam int unsigned RAND_ITEMS   = 525;
    localparam int unsigned DIR_ROWS     = 25;
    localparam int unsigned DRAIN_CYCLES = 2 * ROWS + 16;
    localparam int unsigned MAX_REPORTS  = 10;

    // opcodes the block ignores, and a bound slot past the last one
    localparam logic [OP_W-1:0]  OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0]  OP_SPARE_HI = 3'd7;
    localparam logic [SEL_W-1:0] SEL_BAD     = 3'd7;

    localparam logic [FIELD_W-1:0] MEAS_ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] MEAS_TOP      = MEAS_ALL_ONES - 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    idx;
        logic [ALERT_W-1:0]  alert;
        logic [STATE_W-1:0]  state;
        logic [ACTION_W-1:0] action;
        logic [STATE_W-1:0]  next;
        logic [SEL_W-1:0]    sel;
        logic [FIELD_W-1:0]  bval;
        logic [FIELD_W-1:0]  lat;
        logic [FIELD_W-1:0]  jit;
        logic [FIELD_W-1:0]  loss;
    } t_qos_cmd;

    typedef struct packed {
        logic                triggered;
        logic [ACTION_W-1:0] action;
        logic [STATE_W-1:0]  state;
        logic [IDX_W-1:0]    row;
    } t_qos_result;

    typedef struct packed {
        t_qos_cmd    cmd;
        logic        typed;
        t_qos_result want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_opcode;
    logic [IDX_W-1:0]    i_rule_index;
    logic [ALERT_W-1:0]  i_alert_type;
    logic [STATE_W-1:0]  i_rule_state;
    logic [ACTION_W-1:0] i_rule_action;
    logic [STATE_W-1:0]  i_rule_next_state;
    logic [SEL_W-1:0]    i_bound_select;
    logic [FIELD_W-1:0]  i_bound_value;
    logic [FIELD_W-1:0]  i_latency;
    logic [FIELD_W-1:0]  i_jitter;
    logic [FIELD_W-1:0]  i_packet_loss;
    logic                o_valid;
    logic                i_ready;
    logic                o_triggered;
    logic [ACTION_W-1:0] o_action_code;
    logic [STATE_W-1:0]  o_state_now;
    logic [IDX_W-1:0]    o_row_used;

    qos_range_rule_state_machine_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_rule_index      (i_rule_index),
        .i_alert_type      (i_alert_type),
        .i_rule_state      (i_rule_state),
        .i_rule_action     (i_rule_action),
        .i_rule_next_state (i_rule_next_state),
        .i_bound_select    (i_bound_select),
        .i_bound_value     (i_bound_value),
        .i_latency         (i_latency),
        .i_jitter          (i_jitter),
        .i_packet_loss     (i_packet_loss),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_triggered       (o_triggered),
        .o_action_code     (o_action_code),
        .o_state_now       (o_state_now),
        .o_row_used        (o_row_used)
    );

    // rule table and machine state as the block should hold them
    logic                tbl_valid  [ROWS];
    logic [STATE_W-1:0]  tbl_state  [ROWS];
    logic [ALERT_W-1:0]  tbl_alert  [ROWS];
    logic [ACTION_W-1:0] tbl_action [ROWS];
    logic [STATE_W-1:0]  tbl_next   [ROWS];
    logic [FIELD_W-1:0]  tbl_bound  [ROWS][BND_SLOTS];
    logic [STATE_W-1:0]  cur_state = '0;
    int unsigned         cur_row   = 0;
    logic [2:0]          oor_flags = '0;   // bit 0 jitter, bit 1 latency, bit 2 loss

    t_qos_result pending_results [$];
    int unsigned mismatches   = 0;
    int unsigned fired_seen   = 0;
    int unsigned op_seen [8]  = '{default: 0};
    logic        no_idle_run  = 1'b0;
    t_qos_result got, want;

    t_dir_row dir_table [DIR_ROWS] = '{
        // empty table after reset: no match, then a recovery through row 0
        '{'{OP_ALERT, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_RECOVER, 5'd0, 2'd3, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b1, '{1'b1, 8'h00, 4'd0, 5'd0}},
        '{'{OP_SPARE_LO, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_SPARE_HI, 5'd31, 2'd3, 4'd15, 8'hFF, 4'd15, 3'd7, MEAS_ALL_ONES, MEAS_TOP,
            MEAS_TOP, MEAS_TOP}, 1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_KEYS, 5'd0, 2'd1, 4'd0, 8'hFF, 4'd15, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_KEYS, 5'd31, 2'd2, 4'd15, 8'hA5, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_BOUND, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, BND_JIT_MAX, 24'd100, 24'd0, 24'd0,
            24'd0}, 1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_BOUND, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, SEL_BAD, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        '{'{OP_ALERT, 5'd0, 2'd1, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd1, 24'd50, 24'd0},
          1'b1, '{1'b0, 8'h00, 4'd0, 5'd0}},
        // jitter equal to its max is out of range
        '{'{OP_ALERT, 5'd0, 2'd1, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd1, 24'd100, 24'd0},
          1'b1, '{1'b1, 8'hFF, 4'd15, 5'd0}},
        // jitter equal to its min is out of range as well
        '{'{OP_ALERT, 5'd0, 2'd2, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd5, 24'd0, 24'd0},
          1'b1, '{1'b1, 8'hA5, 4'd0, 5'd31}},
        // no match: old row and old flags still drive a transition
        '{'{OP_ALERT, 5'd0, 2'd3, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd7, 24'd7, 24'd7},
          1'b0, '0},
        '{'{OP_KEYS, 5'd2, 2'd0, 4'd0, 8'h11, 4'd3, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b0, '0},
        '{'{OP_KEYS, 5'd4, 2'd0, 4'd0, 8'h22, 4'd4, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b0, '0},
        // two matches span rows 2 and 3; row 3 is an unwritten gap row
        '{'{OP_ALERT, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, MEAS_TOP, MEAS_TOP,
            MEAS_TOP}, 1'b0, '0},
        '{'{OP_BOUND, 5'd3, 2'd0, 4'd0, 8'h00, 4'd0, BND_LOSS_MAX, MEAS_TOP, 24'd0, 24'd0,
            24'd0}, 1'b0, '0},
        '{'{OP_ALERT, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, MEAS_TOP, MEAS_TOP,
            MEAS_TOP}, 1'b0, '0},
        '{'{OP_BOUND, 5'd2, 2'd0, 4'd0, 8'h00, 4'd0, BND_LOSS_MIN, 24'd5, 24'd0, 24'd0,
            24'd0}, 1'b0, '0},
        '{'{OP_BOUND, 5'd2, 2'd0, 4'd0, 8'h00, 4'd0, BND_LAT_MIN, 24'd9, 24'd0, 24'd0,
            24'd0}, 1'b0, '0},
        '{'{OP_BOUND, 5'd2, 2'd0, 4'd0, 8'h00, 4'd0, BND_LAT_MAX, MEAS_ALL_ONES, 24'd0,
            24'd0, 24'd0}, 1'b0, '0},
        // loss equal to its min passes, latency equal to its min fails
        '{'{OP_ALERT, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd10, 24'd1, 24'd5},
          1'b0, '0},
        '{'{OP_ALERT, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd9, 24'd1, 24'd5},
          1'b0, '0},
        '{'{OP_RECOVER, 5'd0, 2'd1, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b0, '0},
        '{'{OP_CLEAR, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b0, '0},
        '{'{OP_ALERT, 5'd0, 2'd0, 4'd0, 8'h00, 4'd0, 3'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          1'b0, '0}
    };

    function automatic void wipe_rule_table();
        for (int unsigned r = 0; r < ROWS; r++) begin
            tbl_valid[r]  = 1'b0;
            tbl_state[r]  = '0;
            tbl_alert[r]  = '0;
            tbl_action[r] = '0;
            tbl_next[r]   = '0;
            for (int unsigned k = 0; k < BND_SLOTS; k++) begin
                tbl_bound[r][k] = k[0] ? MEAS_ALL_ONES : '0;
            end
        end
    endfunction

    // an all-ones max means no upper bound
    function automatic logic band_ok(input logic [FIELD_W-1:0] v, input logic [FIELD_W-1:0] lo,
                                     input logic [FIELD_W-1:0] hi, input logic strict_lo);
        return (strict_lo ? (v > lo) : (v >= lo)) && (hi == MEAS_ALL_ONES || v < hi);
    endfunction

    function automatic t_qos_result qos_predict(input t_qos_cmd c);
        t_qos_result r;
        int unsigned hits, base, row;
        logic        stop, fired;
        r     = '0;
        fired = 1'b0;
        case (c.op)
            OP_KEYS: begin
                if (c.idx < ROWS) begin
                    tbl_valid[c.idx]  = 1'b1;
                    tbl_alert[c.idx]  = c.alert;
                    tbl_state[c.idx]  = c.state;
                    tbl_action[c.idx] = c.action;
                    tbl_next[c.idx]   = c.next;
                end
            end
            OP_BOUND: begin
                if (c.idx < ROWS && c.sel < BND_SLOTS) tbl_bound[c.idx][c.sel] = c.bval;
            end
            OP_ALERT, OP_RECOVER: begin
                hits = 0;
                for (int unsigned k = 0; k < ROWS; k++) begin
                    if (tbl_valid[k] && tbl_state[k] == cur_state && tbl_alert[k] == c.alert) begin
                        if (hits == 0) cur_row = k;
                        hits++;
                    end
                end
                if (c.op == OP_ALERT) begin
                    base = cur_row;
                    stop = 1'b0;
                    // test jitter, latency, loss per row; stop at the first violation
                    for (int unsigned k = 0; k < hits && !stop && base + k < ROWS; k++) begin
                        row = base + k;
                        if (!band_ok(c.jit, tbl_bound[row][BND_JIT_MIN],
                                     tbl_bound[row][BND_JIT_MAX], 1'b1)) begin
                            oor_flags[0] = 1'b1;
                            stop = 1'b1;
                        end else begin
                            oor_flags[0] = 1'b0;
                            if (!band_ok(c.lat, tbl_bound[row][BND_LAT_MIN],
                                         tbl_bound[row][BND_LAT_MAX], 1'b1)) begin
                                oor_flags[1] = 1'b1;
                                stop = 1'b1;
                            end else begin
                                oor_flags[1] = 1'b0;
                                if (!band_ok(c.loss, tbl_bound[row][BND_LOSS_MIN],
                                             tbl_bound[row][BND_LOSS_MAX], 1'b0)) begin
                                    oor_flags[2] = 1'b1;
                                    stop = 1'b1;
                                end else begin
                                    oor_flags[2] = 1'b0;
                                end
                            end
                        end
                        if (stop) cur_row = row;
                    end
                    fired = (oor_flags != '0);
                end else begin
                    fired = 1'b1;
                end
                if (fired) begin
                    cur_state = tbl_next[cur_row];
                    r.action  = tbl_action[cur_row];
                end
            end
            OP_CLEAR: wipe_rule_table();
            default: ;
        endcase
        r.triggered = fired;
        r.state     = cur_state;
        r.row       = cur_row[IDX_W-1:0];
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_measure();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 7) return FIELD_W'($urandom_range(0, 63));
        if (k < 8) return MEAS_TOP;
        return FIELD_W'($urandom_range(0, MEAS_TOP));
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer, valid still high
    task automatic push_cmd(input t_qos_cmd c, input logic typed, input t_qos_result typed_want);
        t_qos_result p;
        while (!no_idle_run && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode          = c.op;
        i_rule_index      = c.idx;
        i_alert_type      = c.alert;
        i_rule_state      = c.state;
        i_rule_action     = c.action;
        i_rule_next_state = c.next;
        i_bound_select    = c.sel;
        i_bound_value     = c.bval;
        i_latency         = c.lat;
        i_jitter          = c.jit;
        i_packet_loss     = c.loss;
        i_valid           = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p = qos_predict(c);
        pending_results.insert(pending_results.size(), typed ? typed_want : p);
        op_seen[c.op]++;
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("qos_range_rule_state_machine_core test failed");
        $finish;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = no_idle_run || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_triggered, o_action_code, o_state_now, o_row_used};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result trig=%0d act=%02h state=%0d row=%0d",
                             $realtime, got.triggered, got.action, got.state, got.row);
            end else begin
                want = pending_results.pop_front();
                if (want.triggered) fired_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: result mismatch: expected trig=%0d act=%02h state=%0d ",
                                  "row=%0d, got trig=%0d act=%02h state=%0d row=%0d"},
                                 $realtime, want.triggered, want.action, want.state, want.row,
                                 got.triggered, got.action, got.state, got.row);
                end
            end
        end
    end

    initial begin : stimulus
        t_qos_cmd    c;
        int unsigned pick;
        int unsigned spare_seen;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_opcode          = '0;
        i_rule_index      = '0;
        i_alert_type      = '0;
        i_rule_state      = '0;
        i_rule_action     = '0;
        i_rule_next_state = '0;
        i_bound_select    = '0;
        i_bound_value     = '0;
        i_latency         = '0;
        i_jitter          = '0;
        i_packet_loss     = '0;
        wipe_rule_table();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int unsigned n = 0; n < DIR_ROWS; n++) begin
            push_cmd(dir_table[n].cmd, dir_table[n].typed, dir_table[n].want);
        end

        for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
            no_idle_run = (n >= 200 && n < 300);
            // hold off until the block has drained everything
            if (n % 131 == 0) begin
                i_valid = 1'b0;
                while (pending_results.size() != 0) @(negedge i_clk);
            end

            c.op     = OP_ALERT;
            c.idx    = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 7))
                                                  : IDX_W'($urandom_range(0, ROWS - 1));
            c.alert  = ALERT_W'($urandom_range(0, 3));
            c.state  = STATE_W'($urandom_range(0, 15));
            c.action = ACTION_W'($urandom_range(0, 255));
            c.next   = ($urandom_range(0, 9) < 7) ? STATE_W'($urandom_range(0, 3))
                                                  : STATE_W'($urandom_range(0, 15));
            c.sel    = ($urandom_range(0, 9) < 9) ? SEL_W'($urandom_range(0, BND_SLOTS - 1))
                                                  : SEL_W'($urandom_range(BND_SLOTS, SEL_BAD));
            c.bval   = FIELD_W'($urandom);
            c.lat    = pick_measure();
            c.jit    = pick_measure();
            c.loss   = pick_measure();

            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                c.op = OP_KEYS;
                // most rows key on the present state so alerts find matches
                if ($urandom_range(0, 1) != 0) c.state = cur_state;
            end else if (pick < 45) begin
                c.op = OP_BOUND;
                pick = $urandom_range(0, 99);
                if (pick < 60)      c.bval = FIELD_W'($urandom_range(0, 63));
                else if (pick < 75) c.bval = MEAS_ALL_ONES;
                else if (pick < 85) c.bval = '0;
            end else if (pick < 80) begin
                c.op = OP_ALERT;
            end else if (pick < 92) begin
                c.op = OP_RECOVER;
            end else if (pick < 94) begin
                c.op = OP_CLEAR;
            end else if (pick < 97) begin
                c.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            push_cmd(c, 1'b0, '0);
        end

        i_valid     = 1'b0;
        no_idle_run = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        spare_seen = 0;
        for (int unsigned k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
            spare_seen += op_seen[k];
        end
        $display("covered %0d key writes, %0d bound writes, %0d alerts, %0d recoveries,",
                 op_seen[OP_KEYS], op_seen[OP_BOUND], op_seen[OP_ALERT], op_seen[OP_RECOVER]);
        $display("%0d table clears, %0d ignored opcodes; %0d results carried a transition",
                 op_seen[OP_CLEAR], spare_seen, fired_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("qos_range_rule_state_machine_core test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("qos_range_rule_state_machine_core test failed");
        end
        $finish;
    end

endmodule
